FILE: sv/gbn_pkg.sv
// Shared types and constants for the Go-Back-N sender window.
// No dependencies; every other file but gbn_ram refers to this package by scoped names.
`default_nettype none

package gbn_pkg;

    // Fixed field widths of the channels
    localparam int OP_W       = 2;
    localparam int PAY_W      = 32;
    localparam int SEQ_W      = 4;
    localparam int TMR_W      = 2;
    localparam int CNT_OUT_W  = 4;
    localparam int LIMIT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int MISS_W     = 3;

    // Sequence space wraps at 2**SEQ_W
    localparam int SEQ_MODULUS  = 2 ** SEQ_W;
    localparam int PAYLOAD_BITS = PAY_W;
    localparam logic [SEQ_W-1:0] INITIAL_SEQ = SEQ_W'(0);

    localparam int DEF_WINDOW_DEPTH = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4);
    localparam logic [MISS_W-1:0]  MISS_LIMIT  = MISS_W'(4);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_RESEND  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT = CFG_IDX_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_SEND    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [TMR_W-1:0] {
        TMR_NONE    = 2'd0,
        TMR_RESTART = 2'd1,
        TMR_STOP    = 2'd2
    } t_tmr;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic               fast_en;
        logic [LIMIT_W-1:0] window_limit;
    } t_cfg;

    typedef struct packed {
        logic                 send_accepted;
        logic                 pkt_valid;
        logic [SEQ_W-1:0]     pkt_seq;
        logic [PAY_W-1:0]     pkt_payload;
        t_tmr                 timer_cmd;
        logic                 fast_resend_fired;
        logic [CNT_OUT_W-1:0] window_count;
        logic                 window_full;
        logic                 last;
    } t_result;

    typedef struct packed {
        logic busy;
        logic rd_pend;
    } t_stat;

endpackage

`default_nettype wire

FILE: sv/gbn_if.sv
// Handshake channels of the sender window: event input, result output, config writes.
// Depends on gbn_pkg for field widths.
`default_nettype none

interface gbn_in_if;
    logic                       valid;
    logic                       ready;
    logic [gbn_pkg::OP_W-1:0]   op;
    logic [gbn_pkg::PAY_W-1:0]  payload;
    logic [gbn_pkg::SEQ_W-1:0]  ack_num;
    logic                       ack_checksum_ok;

    modport source (output valid, op, payload, ack_num, ack_checksum_ok, input ready);
    modport sink   (input valid, op, payload, ack_num, ack_checksum_ok, output ready);
endinterface

interface gbn_out_if;
    logic                          valid;
    logic                          ready;
    logic                          send_accepted;
    logic                          pkt_valid;
    logic [gbn_pkg::SEQ_W-1:0]     pkt_seq;
    logic [gbn_pkg::PAY_W-1:0]     pkt_payload;
    logic [gbn_pkg::TMR_W-1:0]     timer_cmd;
    logic                          fast_resend_fired;
    logic [gbn_pkg::CNT_OUT_W-1:0] window_count;
    logic                          window_full;
    logic                          last;

    modport source (output valid, send_accepted, pkt_valid, pkt_seq, pkt_payload, timer_cmd,
                    fast_resend_fired, window_count, window_full, last, input ready);
    modport sink   (input valid, send_accepted, pkt_valid, pkt_seq, pkt_payload, timer_cmd,
                    fast_resend_fired, window_count, window_full, last, output ready);
endinterface

interface gbn_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gbn_pkg::CFG_IDX_W-1:0]   index;
    logic [gbn_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/gbn_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module gbn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                    i_wdata,
    input  wire logic                                i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/gbn_cfg.sv
// Configuration registers: fast resend enable and window limit.
// Depends on gbn_pkg and the gbn_cfg_if channel.
`default_nettype none

module gbn_cfg (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    gbn_cfg_if.sink      i_cfg,
    output gbn_pkg::t_cfg o_cfg
);

    gbn_pkg::t_cfg r_cfg;

    assign i_cfg.ready = i_rst_n;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_en      <= 1'b0;
            r_cfg.window_limit <= gbn_pkg::LIMIT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                gbn_pkg::CFG_FAST_RESEND: begin
                    r_cfg.fast_en <= i_cfg.data[0];
                end
                gbn_pkg::CFG_WINDOW_LIMIT: begin
                    r_cfg.window_limit <= i_cfg.data[gbn_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/gbn_ctrl.sv
// Window control: event decode, window state, ring read engine and result register.
// Depends on gbn_pkg and the gbn_in_if / gbn_out_if channels; drives the ring RAM.
`default_nettype none

module gbn_ctrl #(
    parameter int WINDOW_DEPTH = gbn_pkg::DEF_WINDOW_DEPTH
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire gbn_pkg::t_cfg                               i_cfg,
    gbn_in_if.sink                                           i_in,
    gbn_out_if.source                                        o_out,
    output logic                                             o_ram_we,
    output logic [(WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1)-1:0] o_ram_waddr,
    output logic [gbn_pkg::PAY_W-1:0]                        o_ram_wdata,
    output logic                                             o_ram_re,
    output logic [(WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1)-1:0] o_ram_raddr,
    input  wire logic [gbn_pkg::PAY_W-1:0]                   i_ram_rdata,
    output gbn_pkg::t_stat                                   o_stat
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int LW = (CW > gbn_pkg::LIMIT_W) ? CW : gbn_pkg::LIMIT_W;
    localparam int SW = gbn_pkg::SEQ_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(WINDOW_DEPTH);

    // Ring index add; both operands keep the sum below twice the depth
    function automatic logic [AW-1:0] idx_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(WINDOW_DEPTH)) begin
            s = s - (CW+1)'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    gbn_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [SW-1:0]   r_base, n_base;
    logic [gbn_pkg::MISS_W-1:0] r_miss, n_miss;

    logic [CW-1:0]   r_rd_left, n_rd_left;
    logic [AW-1:0]   r_rd_addr, n_rd_addr;
    logic [SW-1:0]   r_rd_seq, n_rd_seq;
    logic            r_rd_pend, n_rd_pend;
    logic [SW-1:0]   r_pend_seq, n_pend_seq;
    logic            r_pend_last, n_pend_last;
    logic            r_rd_fast, n_rd_fast;
    gbn_pkg::t_tmr   r_fast_tmr, n_fast_tmr;

    logic             r_ov, n_ov;
    gbn_pkg::t_result r_out;

    logic             in_ready, accept, out_free;
    logic             start_read, direct_load, fire;
    logic             rd_issue, rd_load, rd_done;
    gbn_pkg::t_op     op;
    gbn_pkg::t_tmr    ack_tmr;
    gbn_pkg::t_result direct_res, rd_res;
    logic [LW-1:0]    eff_limit, lim_ext;
    logic             full_now;
    logic [SW-1:0]    drop_seq;
    logic [CW-1:0]    drop;
    logic [gbn_pkg::MISS_W-1:0] miss_inc;

    assign op        = gbn_pkg::t_op'(i_in.op);
    assign out_free  = !r_ov || o_out.ready;
    assign in_ready  = i_rst_n && (r_state == gbn_pkg::ST_IDLE) && out_free;
    assign accept    = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // Limit of zero acts as one, anything above the ring depth as the depth
    assign lim_ext   = LW'(i_cfg.window_limit);
    assign eff_limit = (lim_ext == '0) ? LW'(1) : ((lim_ext > DEPTH_L) ? DEPTH_L : lim_ext);
    assign full_now  = LW'(r_count) >= eff_limit;

    assign drop_seq  = i_in.ack_num - r_base;
    assign drop      = (LW'(drop_seq) > LW'(r_count)) ? r_count : CW'(drop_seq);
    assign miss_inc  = r_miss + gbn_pkg::MISS_W'(1);

    assign rd_load  = r_rd_pend && out_free;
    assign rd_issue = (r_state == gbn_pkg::ST_READ) && (r_rd_left != '0) &&
                      (!r_rd_pend || rd_load);
    assign rd_done  = (r_state == gbn_pkg::ST_READ) && (r_rd_left == '0) &&
                      (!r_rd_pend || rd_load);

    always_comb begin : next_state
        n_state = r_state;
        case (r_state)
            gbn_pkg::ST_IDLE: begin
                if (start_read) begin
                    n_state = gbn_pkg::ST_READ;
                end
            end
            gbn_pkg::ST_READ: begin
                if (rd_done) begin
                    n_state = gbn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gbn_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin : datapath
        n_head      = r_head;
        n_count     = r_count;
        n_base      = r_base;
        n_miss      = r_miss;
        n_rd_left   = r_rd_left;
        n_rd_addr   = r_rd_addr;
        n_rd_seq    = r_rd_seq;
        n_pend_seq  = r_pend_seq;
        n_pend_last = r_pend_last;
        n_rd_fast   = r_rd_fast;
        n_fast_tmr  = r_fast_tmr;
        start_read  = 1'b0;
        direct_load = 1'b0;
        fire        = 1'b0;
        ack_tmr     = gbn_pkg::TMR_NONE;
        o_ram_we    = 1'b0;
        o_ram_re    = 1'b0;
        direct_res  = '0;
        direct_res.timer_cmd = gbn_pkg::TMR_NONE;
        direct_res.last      = 1'b1;

        if (accept) begin
            case (op)
                gbn_pkg::OP_SEND: begin
                    direct_load = 1'b1;
                    if (!full_now) begin
                        o_ram_we                 = 1'b1;
                        n_count                  = r_count + CW'(1);
                        direct_res.send_accepted = 1'b1;
                        direct_res.pkt_valid     = 1'b1;
                        direct_res.pkt_seq       = r_base + SW'(r_count);
                        direct_res.pkt_payload   = i_in.payload;
                        direct_res.timer_cmd     = gbn_pkg::TMR_RESTART;
                    end
                end
                gbn_pkg::OP_ACK: begin
                    if (!i_in.ack_checksum_ok) begin
                        direct_load = 1'b1;
                    end else begin
                        if (i_in.ack_num != r_base + SW'(1)) begin
                            if (miss_inc == gbn_pkg::MISS_LIMIT) begin
                                n_miss = '0;
                                fire   = i_cfg.fast_en && (r_count != '0);
                            end else begin
                                n_miss = miss_inc;
                            end
                        end else begin
                            n_miss = '0;
                        end
                        n_head  = idx_add(r_head, drop);
                        n_count = r_count - drop;
                        n_base  = i_in.ack_num;
                        ack_tmr = (n_count != '0) ? gbn_pkg::TMR_RESTART : gbn_pkg::TMR_STOP;
                        if (fire) begin
                            start_read = 1'b1;
                            n_rd_left  = CW'(1);
                            n_rd_addr  = r_head;
                            n_rd_seq   = r_base;
                            n_rd_fast  = 1'b1;
                            n_fast_tmr = ack_tmr;
                        end else begin
                            direct_load          = 1'b1;
                            direct_res.timer_cmd = ack_tmr;
                        end
                    end
                end
                gbn_pkg::OP_TIMEOUT: begin
                    if (r_count == '0) begin
                        direct_load          = 1'b1;
                        direct_res.timer_cmd = gbn_pkg::TMR_RESTART;
                    end else begin
                        start_read = 1'b1;
                        n_rd_left  = r_count;
                        n_rd_addr  = r_head;
                        n_rd_seq   = r_base;
                        n_rd_fast  = 1'b0;
                    end
                end
                default: begin
                    direct_load = 1'b1;
                end
            endcase
        end

        direct_res.window_count = gbn_pkg::CNT_OUT_W'(n_count);
        direct_res.window_full  = LW'(n_count) >= eff_limit;

        // Issue one ring read per cycle while the result register keeps draining
        if (rd_issue) begin
            o_ram_re    = 1'b1;
            n_rd_addr   = idx_add(r_rd_addr, CW'(1));
            n_rd_left   = r_rd_left - CW'(1);
            n_pend_seq  = r_rd_seq;
            n_pend_last = (r_rd_left == CW'(1));
            n_rd_seq    = r_rd_seq + SW'(1);
        end
        n_rd_pend = rd_issue || (r_rd_pend && !rd_load);
        n_ov      = (r_ov && !o_out.ready) || direct_load || rd_load;
    end

    always_comb begin : read_result
        rd_res                   = '0;
        rd_res.pkt_valid         = 1'b1;
        rd_res.pkt_seq           = r_pend_seq;
        rd_res.pkt_payload       = i_ram_rdata;
        rd_res.fast_resend_fired = r_rd_fast;
        rd_res.last              = r_pend_last;
        rd_res.window_count      = gbn_pkg::CNT_OUT_W'(r_count);
        rd_res.window_full       = full_now;
        if (r_rd_fast) begin
            rd_res.timer_cmd = r_fast_tmr;
        end else begin
            rd_res.timer_cmd = r_pend_last ? gbn_pkg::TMR_RESTART : gbn_pkg::TMR_NONE;
        end
    end

    assign o_ram_waddr = idx_add(r_head, r_count);
    assign o_ram_wdata = i_in.payload;
    assign o_ram_raddr = r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gbn_pkg::ST_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_base    <= gbn_pkg::INITIAL_SEQ;
            r_miss    <= '0;
            r_rd_left <= '0;
            r_rd_pend <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_base    <= n_base;
            r_miss    <= n_miss;
            r_rd_left <= n_rd_left;
            r_rd_pend <= n_rd_pend;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr   <= n_rd_addr;
        r_rd_seq    <= n_rd_seq;
        r_pend_seq  <= n_pend_seq;
        r_pend_last <= n_pend_last;
        r_rd_fast   <= n_rd_fast;
        r_fast_tmr  <= n_fast_tmr;
        if (direct_load) begin
            r_out <= direct_res;
        end else if (rd_load) begin
            r_out <= rd_res;
        end
    end

    assign o_out.valid             = r_ov;
    assign o_out.send_accepted     = r_out.send_accepted;
    assign o_out.pkt_valid         = r_out.pkt_valid;
    assign o_out.pkt_seq           = r_out.pkt_seq;
    assign o_out.pkt_payload       = r_out.pkt_payload;
    assign o_out.timer_cmd         = r_out.timer_cmd;
    assign o_out.fast_resend_fired = r_out.fast_resend_fired;
    assign o_out.window_count      = r_out.window_count;
    assign o_out.window_full       = r_out.window_full;
    assign o_out.last              = r_out.last;

    assign o_stat.busy    = (r_state == gbn_pkg::ST_READ);
    assign o_stat.rd_pend = r_rd_pend;

endmodule

`default_nettype wire

FILE: sv/go_back_n_sender_window.sv
// Go-Back-N sender window, top level: config registers, window control and payload ring.
// Depends on gbn_pkg, gbn_if, gbn_ram, gbn_cfg and gbn_ctrl.
//
// The block keeps unacked payload words in a WINDOW_DEPTH-entry ring RAM, refuses sends
// at the clamped limit, and turns each event (send, ack, timer expiry) into one or more
// result transfers. Sends, acks without a fast resend, corrupt acks, unused op codes and
// timeouts on an empty window write their result straight into the output register, and
// the next input is taken while it waits, as long as the output side keeps up. An ack that
// fires a fast resend reads the front ring entry through the RAM's registered read port:
// the read engine issues the read, the RAM registers the word, the output register takes
// it, and no new input is taken until the engine is idle again. A timeout with N packets
// held replays them through the same read port at one packet per cycle while the output
// register keeps draining; no new input is taken until the last packet has been loaded
// into the output register. Output stalls hold back both readouts.
// The ring has no reset and no clearing pass; only entries written by a send are ever read.
`default_nettype none

module go_back_n_sender_window #(
    parameter int WINDOW_DEPTH = gbn_pkg::DEF_WINDOW_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gbn_cfg_if.sink   i_cfg,
    gbn_in_if.sink    i_in,
    gbn_out_if.source o_out
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    gbn_pkg::t_cfg  cfg;
    gbn_pkg::t_stat stat;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [gbn_pkg::PAY_W-1:0] ram_wdata;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [gbn_pkg::PAY_W-1:0] ram_rdata;

    // Fast resend enable, window limit; user writes only while block is idle; unchecked
    gbn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Payload ring: one write per accepted send, one read per replayed packet
    gbn_ram #(
        .WIDTH (gbn_pkg::PAYLOAD_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Window state, event decode, read engine and output register
    gbn_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_stat      (stat)
    );

    // No new event is taken while a replay or fast resend is still reading the ring
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy |-> !i_in.ready)
        else $error("input ready while ring readout in progress");

    // A read still in flight must keep the engine busy
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !stat.busy |-> !stat.rd_pend)
        else $error("pending ring read left behind after readout");

    // A fast resend is always a single packet that ends its event
    a_fast_is_last_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.fast_resend_fired) |-> (o_out.pkt_valid && o_out.last))
        else $error("fast resend without packet or not last");

    // Only replays give more than one transfer per event, and only the last moves the timer
    a_mid_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |->
            (o_out.pkt_valid && (o_out.timer_cmd == gbn_pkg::TMR_NONE)))
        else $error("non-final transfer is not a plain replay packet");

endmodule

`default_nettype wire

FILE: tb/tb_go_back_n_sender_window.sv
// Self-checking testbench for the Go-Back-N sender window: directed corner cases, then
// random traffic under four pacing mixes, checked against a cycle-free window predictor.
// Depends on gbn_pkg, the gbn_if channel interfaces and the go_back_n_sender_window RTL.
`default_nettype none

module tb_go_back_n_sender_window;

    localparam int DEPTH      = gbn_pkg::DEF_WINDOW_DEPTH;
    // Generous ceiling: far above the slowest legal run at the heaviest stall mix
    localparam int STOP_AFTER = 6_000_000;
    // Slots for expected results still waiting for their transfer
    localparam int EXP_SLOTS  = 256;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gbn_cfg_if cfg_bus ();
    gbn_in_if  ev_bus ();
    gbn_out_if res_bus ();

    go_back_n_sender_window uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (ev_bus),
        .o_out   (res_bus)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Window predictor state: a private copy of what the block should hold
    // ------------------------------------------------------------------
    logic [gbn_pkg::PAY_W-1:0]   win_ring [DEPTH];
    logic [2:0]                  win_head;
    logic [3:0]                  win_held;
    logic [gbn_pkg::SEQ_W-1:0]   win_base;
    logic [gbn_pkg::MISS_W-1:0]  miss_run;
    logic                        fast_en_m;
    logic [gbn_pkg::LIMIT_W-1:0] limit_m;

    gbn_pkg::t_result exp_slots [EXP_SLOTS];
    int               exp_wr = 0;
    int               exp_rd = 0;
    gbn_pkg::t_result want_res;
    int               mismatches = 0;

    // Pacing: percentage of cycles the event side idles and the result side stalls
    int idle_pct  = 0;
    int stall_pct = 0;

    // Expected results not yet matched by a transfer
    function automatic int exp_pending();
        return exp_wr - exp_rd;
    endfunction

    // Clamp the programmed limit the way the block does: 0 acts as 1, above depth as depth
    function automatic logic [3:0] limit_in_force();
        if (limit_m == '0) return 4'd1;
        if (int'(limit_m) > DEPTH) return 4'(DEPTH);
        return limit_m;
    endfunction

    // Queue one expected result; count and full flag reflect the state after the step
    function automatic void push_result(logic acc, logic pv, logic [gbn_pkg::SEQ_W-1:0] seq,
                                        logic [gbn_pkg::PAY_W-1:0] pay, gbn_pkg::t_tmr tmr,
                                        logic fast, logic fin);
        gbn_pkg::t_result r;
        r.send_accepted     = acc;
        r.pkt_valid         = pv;
        r.pkt_seq           = seq;
        r.pkt_payload       = pay;
        r.timer_cmd         = tmr;
        r.fast_resend_fired = fast;
        r.window_count      = win_held;
        r.window_full       = (win_held >= limit_in_force());
        r.last              = fin;
        exp_slots[exp_wr % EXP_SLOTS] = r;
        exp_wr++;
    endfunction

    // Advance the predictor by one accepted event and queue the results it causes
    function automatic void predict_window_event(gbn_pkg::t_op op,
                                                 logic [gbn_pkg::PAY_W-1:0] pay,
                                                 logic [gbn_pkg::SEQ_W-1:0] ack, logic ok);
        logic                      fired;
        logic [gbn_pkg::PAY_W-1:0] fpay;
        logic [gbn_pkg::SEQ_W-1:0] fseq;
        logic [gbn_pkg::SEQ_W-1:0] next_seq;
        logic [gbn_pkg::SEQ_W-1:0] gap;
        logic [3:0]                drop;
        logic [gbn_pkg::SEQ_W-1:0] seq;
        fired = 1'b0;
        fpay  = '0;
        case (op)
            gbn_pkg::OP_SEND: begin
                if (win_held >= limit_in_force()) begin
                    push_result(0, 0, '0, '0, gbn_pkg::TMR_NONE, 0, 1);
                end else begin
                    seq = win_base + gbn_pkg::SEQ_W'(win_held);
                    win_ring[(int'(win_head) + int'(win_held)) % DEPTH] = pay;
                    win_held = win_held + 4'd1;
                    push_result(1, 1, seq, pay, gbn_pkg::TMR_RESTART, 0, 1);
                end
            end
            gbn_pkg::OP_ACK: begin
                if (!ok) begin
                    // corrupt ack: no state change at all
                    push_result(0, 0, '0, '0, gbn_pkg::TMR_NONE, 0, 1);
                end else begin
                    fseq     = win_base;
                    next_seq = win_base + gbn_pkg::SEQ_W'(1);
                    if (ack != next_seq) begin
                        miss_run = miss_run + gbn_pkg::MISS_W'(1);
                        if (miss_run == gbn_pkg::MISS_LIMIT) begin
                            miss_run = '0;
                            if (fast_en_m && win_held != 4'd0) begin
                                fired = 1'b1;
                                fpay  = win_ring[win_head];
                            end
                        end
                    end else begin
                        miss_run = '0;
                    end
                    // drop everything when the ack points beyond the held window
                    gap  = ack - win_base;
                    drop = (4'(gap) > win_held) ? win_held : 4'(gap);
                    win_head = 3'((int'(win_head) + int'(drop)) % DEPTH);
                    win_held = win_held - drop;
                    win_base = ack;
                    push_result(0, fired, fired ? fseq : '0, fpay,
                                (win_held != 4'd0) ? gbn_pkg::TMR_RESTART : gbn_pkg::TMR_STOP,
                                fired, 1);
                end
            end
            gbn_pkg::OP_TIMEOUT: begin
                if (win_held == 4'd0) begin
                    push_result(0, 0, '0, '0, gbn_pkg::TMR_RESTART, 0, 1);
                end else begin
                    // replay the whole window front to back; the timer restarts on the last
                    for (int i = 0; i < int'(win_held); i++) begin
                        push_result(0, 1, win_base + gbn_pkg::SEQ_W'(i),
                                    win_ring[(int'(win_head) + i) % DEPTH],
                                    (i + 1 == int'(win_held)) ? gbn_pkg::TMR_RESTART
                                                              : gbn_pkg::TMR_NONE,
                                    0, (i + 1 == int'(win_held)));
                    end
                end
            end
            default: begin
                push_result(0, 0, '0, '0, gbn_pkg::TMR_NONE, 0, 1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the field-by-field check
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic report_field(string name, logic [gbn_pkg::PAY_W-1:0] want,
                                logic [gbn_pkg::PAY_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Compare every result transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (exp_pending() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual seq %0h payload %0h",
                         $time, res_bus.pkt_seq, res_bus.pkt_payload);
            end else begin
                want_res = exp_slots[exp_rd % EXP_SLOTS];
                exp_rd++;
                report_field("send_accepted", 32'(want_res.send_accepted),
                             32'(res_bus.send_accepted));
                report_field("pkt_valid", 32'(want_res.pkt_valid), 32'(res_bus.pkt_valid));
                report_field("pkt_seq", 32'(want_res.pkt_seq), 32'(res_bus.pkt_seq));
                report_field("pkt_payload", want_res.pkt_payload, res_bus.pkt_payload);
                report_field("timer_cmd", 32'(want_res.timer_cmd), 32'(res_bus.timer_cmd));
                report_field("fast_resend_fired", 32'(want_res.fast_resend_fired),
                             32'(res_bus.fast_resend_fired));
                report_field("window_count", 32'(want_res.window_count),
                             32'(res_bus.window_count));
                report_field("window_full", 32'(want_res.window_full),
                             32'(res_bus.window_full));
                report_field("last", 32'(want_res.last), 32'(res_bus.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Event and configuration drivers
    // ------------------------------------------------------------------

    // Offer one event, idling first at random; predict once the transfer happens
    task automatic send_event(gbn_pkg::t_op op, logic [gbn_pkg::PAY_W-1:0] pay,
                              logic [gbn_pkg::SEQ_W-1:0] ack, logic ok);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            ev_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        ev_bus.valid           <= 1'b1;
        ev_bus.op              <= op;
        ev_bus.payload         <= pay;
        ev_bus.ack_num         <= ack;
        ev_bus.ack_checksum_ok <= ok;
        do @(posedge i_clk); while (!ev_bus.ready);
        predict_window_event(op, pay, ack, ok);
    endtask

    // Drop valid, then hold until every expected result has drained plus a short settle
    task automatic wait_idle();
        @(negedge i_clk);
        ev_bus.valid <= 1'b0;
        while (exp_pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(logic [gbn_pkg::CFG_IDX_W-1:0] idx,
                             logic [gbn_pkg::CFG_DATA_W-1:0] data);
        wait_idle();
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        if (idx == gbn_pkg::CFG_FAST_RESEND) fast_en_m = data[0];
        else if (idx == gbn_pkg::CFG_WINDOW_LIMIT) limit_m = data;
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_pace(int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Fill the reset-size window with extreme payloads, then get a send refused
    task automatic test_send_refuse();
        send_event(gbn_pkg::OP_SEND, 32'h0000_0000, 4'h0, 1'b0);
        send_event(gbn_pkg::OP_SEND, 32'hFFFF_FFFF, 4'hF, 1'b1);
        send_event(gbn_pkg::OP_SEND, 32'hA5A5_A5A5, 4'h5, 1'b0);
        send_event(gbn_pkg::OP_SEND, 32'h5A5A_5A5A, 4'hA, 1'b1);
        send_event(gbn_pkg::OP_SEND, 32'h1234_5678, 4'h0, 1'b0);
    endtask

    // Replay a full window, advance by one, replay the rest
    task automatic test_timeout_replay();
        send_event(gbn_pkg::OP_TIMEOUT, 32'h0, 4'h0, 1'b0);
        send_event(gbn_pkg::OP_ACK, 32'h0, win_base + gbn_pkg::SEQ_W'(1), 1'b1);
        send_event(gbn_pkg::OP_TIMEOUT, 32'hFFFF_FFFF, 4'hF, 1'b1);
    endtask

    // Corrupt ack, unused op, ack beyond the window, timeout on an empty window
    task automatic test_ack_corners();
        send_event(gbn_pkg::OP_ACK, 32'h0, 4'hF, 1'b0);
        send_event(gbn_pkg::OP_NONE, 32'hFFFF_FFFF, 4'hF, 1'b1);
        send_event(gbn_pkg::OP_ACK, 32'h0, win_base + gbn_pkg::SEQ_W'(10), 1'b1);
        send_event(gbn_pkg::OP_TIMEOUT, 32'h0, 4'h0, 1'b0);
    endtask

    // Four unexpected acks with fast resend on: with the miss left by the ack corner test, the third resends the front
    task automatic test_fast_resend();
        write_reg(gbn_pkg::CFG_FAST_RESEND, 4'hF);
        send_event(gbn_pkg::OP_SEND, 32'hDEAD_0001, 4'h0, 1'b0);
        send_event(gbn_pkg::OP_SEND, 32'hDEAD_0002, 4'h0, 1'b0);
        repeat (4) send_event(gbn_pkg::OP_ACK, $urandom(), win_base, 1'b1);
    endtask

    // Widest window, limit lowered under the held count, and the clamped extremes
    task automatic test_limit_extremes();
        write_reg(gbn_pkg::CFG_WINDOW_LIMIT, 4'd8);
        while (win_held < 4'd8) send_event(gbn_pkg::OP_SEND, $urandom(), 4'h0, 1'b1);
        send_event(gbn_pkg::OP_SEND, 32'hFFFF_FFFF, 4'h0, 1'b1);
        send_event(gbn_pkg::OP_TIMEOUT, 32'h0, 4'h0, 1'b0);
        write_reg(gbn_pkg::CFG_WINDOW_LIMIT, 4'd2);
        send_event(gbn_pkg::OP_SEND, 32'h0BAD_0BAD, 4'h0, 1'b1);
        send_event(gbn_pkg::OP_ACK, 32'h0, win_base + gbn_pkg::SEQ_W'(win_held), 1'b1);
        write_reg(gbn_pkg::CFG_WINDOW_LIMIT, 4'd0);
        send_event(gbn_pkg::OP_SEND, 32'h0000_0001, 4'h0, 1'b1);
        send_event(gbn_pkg::OP_SEND, 32'h8000_0000, 4'h0, 1'b1);
        write_reg(gbn_pkg::CFG_WINDOW_LIMIT, 4'd15);
        send_event(gbn_pkg::OP_SEND, 32'h7FFF_FFFF, 4'h0, 1'b1);
        send_event(gbn_pkg::OP_TIMEOUT, 32'h0, 4'h0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed send/ack flow, plus noise
    // ------------------------------------------------------------------
    task automatic test_random_traffic(int items);
        int                        pick;
        int                        done;
        logic [gbn_pkg::SEQ_W-1:0] ack;
        done = 0;
        while (done < items) begin
            pick = $urandom_range(0, 99);
            if (pick < 44) begin
                send_event(gbn_pkg::OP_SEND,
                           ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom(),
                           gbn_pkg::SEQ_W'($urandom()), 1'($urandom()));
                done++;
            end else if (pick < 70) begin
                // in-window ack most of the time, a stale or duplicate one otherwise
                if (win_held != 4'd0 && $urandom_range(0, 4) != 0)
                    ack = win_base + gbn_pkg::SEQ_W'($urandom_range(1, int'(win_held)));
                else
                    ack = win_base;
                send_event(gbn_pkg::OP_ACK, $urandom(), ack, 1'b1);
                done++;
            end else if (pick < 78) begin
                // burst of duplicate acks to reach the fast resend threshold
                repeat (4) send_event(gbn_pkg::OP_ACK, $urandom(), win_base, 1'b1);
                done += 4;
            end else if (pick < 88) begin
                send_event(gbn_pkg::OP_TIMEOUT, $urandom(), gbn_pkg::SEQ_W'($urandom()),
                           1'($urandom()));
                done++;
            end else if (pick < 94) begin
                send_event(gbn_pkg::OP_ACK, $urandom(), gbn_pkg::SEQ_W'($urandom()),
                           1'($urandom()));
                done++;
            end else begin
                send_event(gbn_pkg::t_op'($urandom_range(0, 3)), $urandom(),
                           gbn_pkg::SEQ_W'($urandom()), 1'($urandom()));
                done++;
            end
            // move the limit partway through a phase so the window shrinks under load
            if (done >= items / 2 && done < items / 2 + 1)
                write_reg(gbn_pkg::CFG_WINDOW_LIMIT,
                          gbn_pkg::LIMIT_W'($urandom_range(0, 15)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n                = 1'b0;
        ev_bus.valid           = 1'b0;
        ev_bus.op              = gbn_pkg::OP_SEND;
        ev_bus.payload         = '0;
        ev_bus.ack_num         = '0;
        ev_bus.ack_checksum_ok = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = gbn_pkg::CFG_FAST_RESEND;
        cfg_bus.data           = '0;

        win_head  = '0;
        win_held  = '0;
        win_base  = gbn_pkg::INITIAL_SEQ;
        miss_run  = '0;
        fast_en_m = 1'b0;
        limit_m   = gbn_pkg::LIMIT_RESET;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_pace(0, 0);
        test_send_refuse();
        test_timeout_replay();
        test_ack_corners();
        test_fast_resend();
        test_limit_extremes();

        write_reg(gbn_pkg::CFG_FAST_RESEND, 4'h1);
        write_reg(gbn_pkg::CFG_WINDOW_LIMIT, 4'd8);
        set_pace(0, 0);
        test_random_traffic(112);

        write_reg(gbn_pkg::CFG_FAST_RESEND, 4'hE);
        write_reg(gbn_pkg::CFG_WINDOW_LIMIT, 4'd1);
        set_pace(49, 0);
        test_random_traffic(112);

        write_reg(gbn_pkg::CFG_FAST_RESEND, 4'h1);
        write_reg(gbn_pkg::CFG_WINDOW_LIMIT, gbn_pkg::LIMIT_W'($urandom_range(0, 15)));
        set_pace(0, 49);
        test_random_traffic(112);

        write_reg(gbn_pkg::CFG_WINDOW_LIMIT, 4'd3);
        set_pace(36, 36);
        test_random_traffic(112);

        // Drain, then leave room for any stray result before the verdict
        wait_idle();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && exp_pending() == 0) begin
            $display("go_back_n_sender_window verification clean");
        end else begin
            $display("go_back_n_sender_window verification failed");
        end
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        #(STOP_AFTER);
        $display("go_back_n_sender_window verification failed");
        $finish;
    end

endmodule

`default_nettype wire
